[hdl/rfc_pkg.sv]
// ----------------------------------------------------------------------------
// rfc_pkg: shared types and constants for the frame checker
// Transfer structs, verdict codes, header layout and the CRC-32 byte update.
// ----------------------------------------------------------------------------
`default_nettype none

package rfc_pkg;

  // Header layout, in byte positions from the start of the frame
  localparam int unsigned HeaderBytes = 8;
  localparam int unsigned CrcStart    = 4;
  localparam int unsigned LenStart    = 6;

  localparam int unsigned CountW = 17;
  localparam logic [CountW-1:0] CountMax = '1;

  localparam logic [31:0] CrcPoly = 32'hEDB8_8320;
  localparam logic [31:0] CrcInit = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_SHORT     = 2'd1,
    STATUS_CRC_ERR   = 2'd2,
    STATUS_LEN_ERR   = 2'd3
  } status_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last;
  } byte_item_t;

  typedef struct packed {
    status_t     status;
    logic [15:0] msg_type;
    logic [15:0] payload_length;
  } verdict_item_t;

  // Reflected CRC-32, one byte, LSB first
  function automatic logic [31:0] crc_byte(input logic [31:0] crc_in,
                                           input logic [7:0]  data);
    logic [31:0] c;
    c = crc_in ^ {24'd0, data};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

[hdl/rpc_frame_checker_crc32.sv]
// ----------------------------------------------------------------------------
// rpc_frame_checker_crc32: framed message checker with CRC-32
// Checks header length, stored CRC and declared payload length per frame.
// ----------------------------------------------------------------------------
//   channel   dir  fields                                       transfer
//   byte      in   data_byte[8], last[1]                        byte_valid & byte_ready
//   verdict   out  status[2], msg_type[16], payload_length[16]  verdict_valid & verdict_ready
//
// One byte per cycle sustained while the verdict is not stalled. A byte passes the
// input register before it reaches the frame state; a last byte loads the verdict
// register at the same edge as the frame state, and the verdict is offered from there.
// The per-cycle path is one byte-wide CRC-32 update plus the verdict compares.
// Synchronous reset clears both stages and the frame state.
// A stalled verdict holds only the last byte of the next frame; earlier bytes
// of that frame keep flowing.
// ----------------------------------------------------------------------------
`default_nettype none

module rpc_frame_checker_crc32 (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  byte_valid,
  output logic                       byte_ready,
  input  wire rfc_pkg::byte_item_t   byte_data,
  output logic                       verdict_valid,
  input  wire logic                  verdict_ready,
  output rfc_pkg::verdict_item_t     verdict_data
);

  logic                held_valid;
  logic                held_take;
  rfc_pkg::byte_item_t held_data;

  rfc_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_ready (byte_ready),
    .byte_data  (byte_data),
    .held_valid (held_valid),
    .held_data  (held_data),
    .held_take  (held_take)
  );

  rfc_check u_check (
    .clk           (clk),
    .rst           (rst),
    .held_valid    (held_valid),
    .held_data     (held_data),
    .held_take     (held_take),
    .verdict_valid (verdict_valid),
    .verdict_ready (verdict_ready),
    .verdict_data  (verdict_data)
  );

endmodule

`default_nettype wire

[hdl/rfc_in_stage.sv]
// ----------------------------------------------------------------------------
// rfc_in_stage: input register for frame bytes
// Holds one byte transfer; refills in the same cycle it is drained.
// ----------------------------------------------------------------------------
`default_nettype none

module rfc_in_stage (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               byte_valid,
  output logic                    byte_ready,
  input  wire rfc_pkg::byte_item_t byte_data,
  output logic                    held_valid,
  output rfc_pkg::byte_item_t     held_data,
  input  wire logic               held_take
);

  // Free when empty or when the held byte leaves this cycle
  assign byte_ready = !held_valid || held_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (byte_ready) begin
      held_valid <= byte_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_valid && byte_ready) begin
      held_data <= byte_data;
    end
  end

endmodule

`default_nettype wire

[hdl/rfc_check.sv]
// ----------------------------------------------------------------------------
// rfc_check: header capture, running CRC and verdict register
// Updates frame state per byte; on the last byte registers one verdict.
// ----------------------------------------------------------------------------
`default_nettype none

module rfc_check (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  held_valid,
  input  wire rfc_pkg::byte_item_t   held_data,
  output logic                       held_take,
  output logic                       verdict_valid,
  input  wire logic                  verdict_ready,
  output rfc_pkg::verdict_item_t     verdict_data
);

  localparam int unsigned CW = rfc_pkg::CountW;

  logic [31:0]   running_crc, running_crc_next;
  logic [CW-1:0] byte_count, byte_count_next;
  logic [31:0]   stored_crc, stored_crc_next;
  logic [15:0]   type_word, type_word_next;
  logic [15:0]   length_word, length_word_next;
  logic          result_free;
  rfc_pkg::verdict_item_t verdict_next;

  // A last byte needs a free result register; other bytes always pass
  assign result_free = !verdict_valid || verdict_ready;
  assign held_take   = held_valid && (!held_data.last || result_free);

  // Per-byte state update
  always_comb begin
    stored_crc_next  = stored_crc;
    type_word_next   = type_word;
    length_word_next = length_word;
    running_crc_next = running_crc;
    if (byte_count < CW'(rfc_pkg::CrcStart)) begin
      stored_crc_next = {stored_crc[23:0], held_data.data_byte};
    end else if (byte_count < CW'(rfc_pkg::LenStart)) begin
      type_word_next = {type_word[7:0], held_data.data_byte};
    end else if (byte_count < CW'(rfc_pkg::HeaderBytes)) begin
      length_word_next = {length_word[7:0], held_data.data_byte};
    end
    if (byte_count >= CW'(rfc_pkg::CrcStart)) begin
      running_crc_next = rfc_pkg::crc_byte(running_crc, held_data.data_byte);
    end
    byte_count_next = (byte_count != rfc_pkg::CountMax) ? byte_count + CW'(1)
                                                         : byte_count;
  end

  // Verdict: short frame, then CRC, then declared length
  always_comb begin
    verdict_next.msg_type       = type_word_next;
    verdict_next.payload_length = length_word_next;
    if (byte_count_next < CW'(rfc_pkg::HeaderBytes)) begin
      verdict_next.status         = rfc_pkg::STATUS_SHORT;
      verdict_next.msg_type       = '0;
      verdict_next.payload_length = '0;
    end else if (~running_crc_next != stored_crc_next) begin
      verdict_next.status = rfc_pkg::STATUS_CRC_ERR;
    end else if (byte_count_next == rfc_pkg::CountMax ||
                 {1'b0, length_word_next} !=
                 byte_count_next - CW'(rfc_pkg::HeaderBytes)) begin
      verdict_next.status = rfc_pkg::STATUS_LEN_ERR;
    end else begin
      verdict_next.status = rfc_pkg::STATUS_OK;
    end
  end

  // Frame state; cleared at reset and after every last byte
  always_ff @(posedge clk) begin
    if (rst) begin
      running_crc <= rfc_pkg::CrcInit;
      byte_count  <= '0;
      stored_crc  <= '0;
      type_word   <= '0;
      length_word <= '0;
    end else if (held_take) begin
      if (held_data.last) begin
        running_crc <= rfc_pkg::CrcInit;
        byte_count  <= '0;
        stored_crc  <= '0;
        type_word   <= '0;
        length_word <= '0;
      end else begin
        running_crc <= running_crc_next;
        byte_count  <= byte_count_next;
        stored_crc  <= stored_crc_next;
        type_word   <= type_word_next;
        length_word <= length_word_next;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      verdict_valid <= 1'b0;
    end else if (result_free) begin
      verdict_valid <= held_take && held_data.last;
    end
  end

  always_ff @(posedge clk) begin
    if (held_take && held_data.last) begin
      verdict_data <= verdict_next;
    end
  end

endmodule

`default_nettype wire

[sim/testbench.sv]
// ----------------------------------------------------------------------------
// testbench: self-checking bench for rpc_frame_checker_crc32
// Drives whole frames byte by byte and predicts each verdict in the bench.
// A short scripted prefix covers short frames and the all-zero and all-one
// headers. Random well-formed frames follow, with CRC and length faults, short
// and noise frames mixed in. A held-off receiver fills the block.
// ----------------------------------------------------------------------------

module testbench;

  localparam int unsigned HdrBytes   = 8;
  localparam int unsigned TypeFirst  = 4;
  localparam int unsigned LenFirst   = 6;
  localparam logic [16:0] CountTop   = 17'h1FFFF;
  localparam logic [31:0] Crc32Poly  = 32'hEDB8_8320;
  localparam int unsigned PhaseBytes = 380;
  localparam int unsigned HoldCycles = 300;
  localparam int unsigned TailCycles = 20;
  localparam int unsigned StallLimit = 4000;

  typedef enum int {
    FRAME_GOOD,
    FRAME_BAD_CRC,
    FRAME_BAD_LEN,
    FRAME_SHORT,
    FRAME_NOISE
  } frame_kind_t;

  // One scripted byte; want is used only where typed is set
  typedef struct packed {
    logic [7:0]             data;
    logic                   last;
    logic                   typed;
    rfc_pkg::verdict_item_t want;
  } script_row_t;

  localparam rfc_pkg::verdict_item_t NoWant    = '{status: rfc_pkg::STATUS_OK,
                                                   msg_type: 16'h0,
                                                   payload_length: 16'h0};
  localparam rfc_pkg::verdict_item_t ShortWant = '{status: rfc_pkg::STATUS_SHORT,
                                                   msg_type: 16'h0,
                                                   payload_length: 16'h0};

  localparam script_row_t ScriptRows [24] = '{
    // one-byte frame right after reset
    '{8'h00, 1'b1, 1'b1, ShortWant},
    // seven bytes: header one byte short, partial type and length stay hidden
    '{8'hA5, 1'b0, 1'b0, NoWant},
    '{8'h5A, 1'b0, 1'b0, NoWant},
    '{8'h3C, 1'b0, 1'b0, NoWant},
    '{8'hC3, 1'b0, 1'b0, NoWant},
    '{8'h12, 1'b0, 1'b0, NoWant},
    '{8'h34, 1'b0, 1'b0, NoWant},
    '{8'h56, 1'b1, 1'b1, ShortWant},
    // all-ones header: CRC matches, declared length does not
    '{8'hFF, 1'b0, 1'b0, NoWant},
    '{8'hFF, 1'b0, 1'b0, NoWant},
    '{8'hFF, 1'b0, 1'b0, NoWant},
    '{8'hFF, 1'b0, 1'b0, NoWant},
    '{8'hFF, 1'b0, 1'b0, NoWant},
    '{8'hFF, 1'b0, 1'b0, NoWant},
    '{8'hFF, 1'b0, 1'b0, NoWant},
    '{8'hFF, 1'b1, 1'b0, NoWant},
    // all-zero header: stored CRC of zero cannot match
    '{8'h00, 1'b0, 1'b0, NoWant},
    '{8'h00, 1'b0, 1'b0, NoWant},
    '{8'h00, 1'b0, 1'b0, NoWant},
    '{8'h00, 1'b0, 1'b0, NoWant},
    '{8'h00, 1'b0, 1'b0, NoWant},
    '{8'h00, 1'b0, 1'b0, NoWant},
    '{8'h00, 1'b0, 1'b0, NoWant},
    '{8'h00, 1'b1, 1'b0, NoWant}
  };

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   byte_valid = 1'b0;
  logic                   byte_ready;
  rfc_pkg::byte_item_t    byte_data = '0;
  logic                   verdict_valid;
  logic                   verdict_ready = 1'b0;
  rfc_pkg::verdict_item_t verdict_data;

  // Predicted frame state
  logic [31:0] frame_crc = 32'hFFFF_FFFF;
  logic [16:0] frame_count = '0;
  logic [31:0] hdr_crc = '0;
  logic [15:0] hdr_type = '0;
  logic [15:0] hdr_len = '0;

  rfc_pkg::verdict_item_t verdict_queue [$];
  logic [7:0]             frame_buf [$];

  int          mismatches = 0;
  int          bytes_sent = 0;
  int          frames_sent = 0;
  int          status_seen [4] = '{0, 0, 0, 0};
  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;
  bit          hold_request = 1'b0;
  int unsigned stall_cycles = 0;

  rpc_frame_checker_crc32 i_dut (
    .clk           (clk),
    .rst           (rst),
    .byte_valid    (byte_valid),
    .byte_ready    (byte_ready),
    .byte_data     (byte_data),
    .verdict_valid (verdict_valid),
    .verdict_ready (verdict_ready),
    .verdict_data  (verdict_data)
  );

  always #5 clk = ~clk;

  // Reflected CRC-32, one data bit per iteration
  function automatic logic [31:0] crc32_next(input logic [31:0] crc_in,
                                             input logic [7:0] data);
    logic [31:0] crc;
    logic        fb;
    crc = crc_in;
    for (int i = 0; i < 8; i++) begin
      fb  = crc[0] ^ data[i];
      crc = crc >> 1;
      if (fb) begin
        crc = crc ^ Crc32Poly;
      end
    end
    return crc;
  endfunction

  // Advance the frame state by one byte; returns 1 with the verdict on last
  function automatic bit frame_step(input rfc_pkg::byte_item_t item,
                                    output rfc_pkg::verdict_item_t v);
    logic [16:0] pos;
    pos = frame_count;
    v   = NoWant;
    if (pos < TypeFirst) begin
      hdr_crc = {hdr_crc[23:0], item.data_byte};
    end else if (pos < LenFirst) begin
      hdr_type = {hdr_type[7:0], item.data_byte};
    end else if (pos < HdrBytes) begin
      hdr_len = {hdr_len[7:0], item.data_byte};
    end
    if (pos >= TypeFirst) begin
      frame_crc = crc32_next(frame_crc, item.data_byte);
    end
    if (frame_count != CountTop) begin
      frame_count = frame_count + 1'b1;
    end
    if (!item.last) begin
      return 1'b0;
    end
    if (frame_count < HdrBytes) begin
      v.status = rfc_pkg::STATUS_SHORT;
    end else begin
      v.msg_type       = hdr_type;
      v.payload_length = hdr_len;
      if (~frame_crc != hdr_crc) begin
        v.status = rfc_pkg::STATUS_CRC_ERR;
      end else if (frame_count == CountTop ||
                   frame_count - HdrBytes != {1'b0, hdr_len}) begin
        v.status = rfc_pkg::STATUS_LEN_ERR;
      end else begin
        v.status = rfc_pkg::STATUS_OK;
      end
    end
    frame_crc   = 32'hFFFF_FFFF;
    frame_count = '0;
    hdr_crc     = '0;
    hdr_type    = '0;
    hdr_len     = '0;
    return 1'b1;
  endfunction

  // One byte transfer, then a random gap at the current sender idle rate
  task automatic send_byte(input rfc_pkg::byte_item_t item, input bit typed,
                           input rfc_pkg::verdict_item_t want);
    rfc_pkg::verdict_item_t v;
    byte_data  <= item;
    byte_valid <= 1'b1;
    do @(posedge clk); while (!byte_ready);
    bytes_sent++;
    if (frame_step(item, v)) begin
      verdict_queue.push_back(typed ? want : v);
      frames_sent++;
    end
    if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      byte_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
    end
  endtask

  task automatic send_frame();
    rfc_pkg::byte_item_t item;
    foreach (frame_buf[i]) begin
      item.data_byte = frame_buf[i];
      item.last      = (i == frame_buf.size() - 1);
      send_byte(item, 1'b0, NoWant);
    end
  endtask

  // Fill frame_buf with one frame of the given kind
  task automatic build_frame(input frame_kind_t kind, input int unsigned payload_len);
    logic [31:0] crc;
    logic [15:0] msg_type;
    logic [15:0] declared;
    int unsigned n;
    int unsigned flip;
    frame_buf.delete();
    if (kind == FRAME_SHORT || kind == FRAME_NOISE) begin
      n = (kind == FRAME_SHORT) ? $urandom_range(HdrBytes - 1, 1) : $urandom_range(24, 1);
      repeat (n) frame_buf.push_back(8'($urandom_range(255)));
    end else begin
      msg_type = 16'($urandom);
      declared = payload_len[15:0];
      if (kind == FRAME_BAD_LEN) begin
        declared = declared + 16'($urandom_range(65535, 1));
      end
      frame_buf.push_back(msg_type[15:8]);
      frame_buf.push_back(msg_type[7:0]);
      frame_buf.push_back(declared[15:8]);
      frame_buf.push_back(declared[7:0]);
      repeat (payload_len) frame_buf.push_back(8'($urandom_range(255)));
      crc = 32'hFFFF_FFFF;
      foreach (frame_buf[i]) begin
        crc = crc32_next(crc, frame_buf[i]);
      end
      crc = ~crc;
      frame_buf.push_front(crc[7:0]);
      frame_buf.push_front(crc[15:8]);
      frame_buf.push_front(crc[23:16]);
      frame_buf.push_front(crc[31:24]);
      // any single flipped bit breaks the CRC
      if (kind == FRAME_BAD_CRC) begin
        flip = $urandom_range(frame_buf.size() - 1);
        frame_buf[flip] = frame_buf[flip] ^ (8'h01 << $urandom_range(7));
      end
    end
  endtask

  // Mostly short payloads, a few longer ones
  function automatic int unsigned pick_payload_len();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 80) begin
      return $urandom_range(12);
    end else if (r < 97) begin
      return $urandom_range(200, 13);
    end
    return $urandom_range(1000, 201);
  endfunction

  task automatic send_random_frame();
    int unsigned pick;
    frame_kind_t kind;
    pick = $urandom_range(99);
    if (pick < 60) begin
      kind = FRAME_GOOD;
    end else if (pick < 72) begin
      kind = FRAME_BAD_CRC;
    end else if (pick < 84) begin
      kind = FRAME_BAD_LEN;
    end else if (pick < 92) begin
      kind = FRAME_SHORT;
    end else begin
      kind = FRAME_NOISE;
    end
    build_frame(kind, pick_payload_len());
    send_frame();
  endtask

  task automatic send_random_bytes(input int count);
    int stop;
    stop = bytes_sent + count;
    while (bytes_sent < stop) begin
      send_random_frame();
    end
  endtask

  // Stop offering bytes until every verdict has come back
  task automatic drain();
    byte_valid <= 1'b0;
    do @(posedge clk); while (verdict_queue.size() != 0);
  endtask

  // Receiver: random ready, or a long hold-off on request
  initial begin
    int unsigned held;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        verdict_ready <= 1'b0;
        for (held = 0; held < HoldCycles; held++) begin
          @(posedge clk);
        end
        hold_request = 1'b0;
      end else begin
        verdict_ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // Verdict check against the oldest prediction
  always @(posedge clk) begin
    rfc_pkg::verdict_item_t want;
    if (!rst && verdict_valid && verdict_ready) begin
      status_seen[verdict_data.status]++;
      if (verdict_queue.size() == 0) begin
        mismatches++;
        $display("%0t: verdict with none expected, expected none actual %h",
                 $time, verdict_data);
      end else begin
        want = verdict_queue.pop_front();
        if (verdict_data.status !== want.status) begin
          mismatches++;
          $display("%0t: status expected %0d actual %0d", $time,
                   want.status, verdict_data.status);
        end
        if (verdict_data.msg_type !== want.msg_type) begin
          mismatches++;
          $display("%0t: msg_type expected %h actual %h", $time,
                   want.msg_type, verdict_data.msg_type);
        end
        if (verdict_data.payload_length !== want.payload_length) begin
          mismatches++;
          $display("%0t: payload_length expected %h actual %h", $time,
                   want.payload_length, verdict_data.payload_length);
        end
      end
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst || (byte_valid && byte_ready) || (verdict_valid && verdict_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles == StallLimit) begin
      $display("%0t: no transfer for %0d cycles", $time, StallLimit);
      $display("Mismatches found");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Main sequence
  initial begin
    rfc_pkg::byte_item_t row_item;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // slow receiver
    tx_idle_pct = 23;
    rx_idle_pct = 85;
    foreach (ScriptRows[r]) begin
      row_item.data_byte = ScriptRows[r].data;
      row_item.last      = ScriptRows[r].last;
      send_byte(row_item, ScriptRows[r].typed, ScriptRows[r].want);
    end
    send_random_bytes(PhaseBytes);
    drain();

    // slow sender, with a full drain halfway
    tx_idle_pct = 85;
    rx_idle_pct = 23;
    send_random_bytes(PhaseBytes / 2);
    drain();
    send_random_bytes(PhaseBytes - PhaseBytes / 2);
    drain();

    // full rate; receiver holds off while good frames with short payloads pile up behind it
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_request = 1'b1;
    repeat (6) begin
      build_frame(FRAME_GOOD, $urandom_range(3));
      send_frame();
    end
    send_random_bytes(PhaseBytes);
    drain();
    repeat (TailCycles) @(posedge clk);

    $display("Covered %0d frames in %0d bytes under three idle mixes",
             frames_sent, bytes_sent);
    $display("and a receiver hold-off; verdicts: ok %0d, short %0d, crc error %0d, %s %0d",
             status_seen[rfc_pkg::STATUS_OK], status_seen[rfc_pkg::STATUS_SHORT],
             status_seen[rfc_pkg::STATUS_CRC_ERR], "length error",
             status_seen[rfc_pkg::STATUS_LEN_ERR]);
    if (mismatches == 0 && verdict_queue.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

[files.f]
hdl/rfc_pkg.sv
hdl/rfc_in_stage.sv
hdl/rfc_check.sv
hdl/rpc_frame_checker_crc32.sv
sim/testbench.sv
